// ===== hw/rtl/lbmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lbmf_pkg;

    localparam int LED_W      = 5;
    localparam int LEVEL_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SPAN1_W    = LED_W + 1;
    localparam int PROD_W     = LEVEL_W + LED_W;
    localparam int REM_W      = LEVEL_W + 1;
    localparam int CNT_W      = LED_W;

    localparam int DEF_MAX_LEDS   = 32;
    localparam int DEF_NUM_RANGES = 2;
    localparam int DEF_COLOR_BITS = 8;

    localparam logic [LEVEL_W-1:0] RST_MAX_VALUE = 16'd100;
    localparam logic [COLOR_W-1:0] RST_FG_COLOR  = 8'd1;
    localparam logic [COLOR_W-1:0] RST_BG_COLOR  = 8'd0;
    localparam logic [1:0]         RST_RANGES    = 2'd1;
    localparam logic [LED_W-1:0]   RST_START0    = 5'd0;
    localparam logic [LED_W-1:0]   RST_END0      = 5'd9;
    localparam logic [LED_W-1:0]   RST_START1    = 5'd0;
    localparam logic [LED_W-1:0]   RST_END1      = 5'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_VALUE    = 3'd0,
        REG_FG_COLOR     = 3'd1,
        REG_BG_COLOR     = 3'd2,
        REG_RANGE_COUNT  = 3'd3,
        REG_FIRST_START  = 3'd4,
        REG_FIRST_END    = 3'd5,
        REG_SECOND_START = 3'd6,
        REG_SECOND_END   = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/led_bar_meter_fill.sv =====
`timescale 1ns / 1ps
`default_nettype none

// LED bar-graph meter fill.
// A level word is taken at a rising edge where start is high and busy is low.
// For each range in use, in range order, the block writes one color word per
// LED of that range, from the lower LED index to the higher one, on led_index
// and color with strobe high for exactly one cycle; last marks the final word
// caused by the level. The receiver cannot stall; within a range, words leave
// one per cycle. Each range takes a setup state, the shared restoring divider
// (one quotient bit per cycle) and then an emit state that writes one word per
// LED. Busy stays high from the accepting edge until the last word has been
// sent and is low in the cycle after it, so a new level is taken only once the
// last word of the previous level has left. A level with no ranges in use
// produces no words and busy stays low. Configuration is written through
// wr_en, wr_index and wr_data; the user must write it only while busy is low,
// as the block does not enforce this. Reset returns the configuration
// registers to their defaults and the block to idle.
module led_bar_meter_fill
    import lbmf_pkg::*;
#(
    parameter int MAX_LEDS   = DEF_MAX_LEDS,
    parameter int NUM_RANGES = DEF_NUM_RANGES,
    parameter int COLOR_BITS = DEF_COLOR_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic [LEVEL_W-1:0]    level,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output      logic                  strobe,
    output      logic [LED_W-1:0]      led_index,
    output      logic [COLOR_W-1:0]    color,
    output      logic                  last
);

    localparam logic [COLOR_W-1:0] COLOR_MASK = (COLOR_BITS >= COLOR_W) ?
        {COLOR_W{1'b1}} : COLOR_W'((1 << COLOR_BITS) - 1);
    localparam logic [LED_W:0]   LED_LIMIT = (LED_W + 1)'(MAX_LEDS);
    localparam logic [LED_W-1:0] LED_TOP   = LED_W'(MAX_LEDS - 1);
    localparam logic [1:0]       RANGE_LIM = 2'(NUM_RANGES);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W - 1);

    logic [LEVEL_W-1:0] max_value_reg;
    logic [COLOR_W-1:0] fg_color_reg;
    logic [COLOR_W-1:0] bg_color_reg;
    logic [1:0]         range_count_reg;
    logic [LED_W-1:0]   start0_reg;
    logic [LED_W-1:0]   end0_reg;
    logic [LED_W-1:0]   start1_reg;
    logic [LED_W-1:0]   end1_reg;

    state_t             state_reg, state_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               range_reg, range_next;
    logic               asc_reg, asc_next;
    logic [LED_W-1:0]   span_reg, span_next;
    logic [LED_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]  dvd_reg, dvd_next;
    logic [LEVEL_W-1:0] rem_reg, rem_next;

    logic [1:0]         num_ranges;
    logic [LEVEL_W-1:0] divisor;
    logic [LED_W-1:0]   raw_start;
    logic [LED_W-1:0]   raw_end;
    logic [LED_W-1:0]   cl_start;
    logic [LED_W-1:0]   cl_end;
    logic               setup_asc;
    logic [LED_W-1:0]   setup_span;
    logic [SPAN1_W-1:0] span_p1;
    logic [PROD_W:0]    product;
    logic [REM_W-1:0]   rem_shift;
    logic               rem_ge;
    logic [REM_W-1:0]   rem_diff;
    logic [LED_W-1:0]   offset;
    logic               lit;
    logic               final_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg   <= RST_MAX_VALUE;
            fg_color_reg    <= RST_FG_COLOR & COLOR_MASK;
            bg_color_reg    <= RST_BG_COLOR & COLOR_MASK;
            range_count_reg <= RST_RANGES;
            start0_reg      <= RST_START0;
            end0_reg        <= RST_END0;
            start1_reg      <= RST_START1;
            end1_reg        <= RST_END1;
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_MAX_VALUE:    max_value_reg   <= wr_data;
                REG_FG_COLOR:     fg_color_reg    <= wr_data[COLOR_W-1:0] & COLOR_MASK;
                REG_BG_COLOR:     bg_color_reg    <= wr_data[COLOR_W-1:0] & COLOR_MASK;
                REG_RANGE_COUNT:  range_count_reg <= wr_data[1:0];
                REG_FIRST_START:  start0_reg      <= wr_data[LED_W-1:0];
                REG_FIRST_END:    end0_reg        <= wr_data[LED_W-1:0];
                REG_SECOND_START: start1_reg      <= wr_data[LED_W-1:0];
                REG_SECOND_END:   end1_reg        <= wr_data[LED_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        num_ranges = (range_count_reg > RANGE_LIM) ? RANGE_LIM : range_count_reg;
        divisor    = (max_value_reg == '0) ? LEVEL_W'(1) : max_value_reg;

        raw_start = range_reg ? start1_reg : start0_reg;
        raw_end   = range_reg ? end1_reg : end0_reg;
        cl_start  = ({1'b0, raw_start} >= LED_LIMIT) ? LED_TOP : raw_start;
        cl_end    = ({1'b0, raw_end} >= LED_LIMIT) ? LED_TOP : raw_end;

        setup_asc  = cl_end > cl_start;
        setup_span = setup_asc ? (cl_end - cl_start) : (cl_start - cl_end);
        span_p1    = {1'b0, setup_span} + SPAN1_W'(1);
        product    = (PROD_W + 1)'(level_reg) * (PROD_W + 1)'(span_p1);

        rem_shift = {rem_reg, dvd_reg[PROD_W-1]};
        rem_ge    = rem_shift >= {1'b0, divisor};
        rem_diff  = rem_shift - {1'b0, divisor};

        // Ascending ranges count the offset up from the start LED; descending
        // ranges count it down toward the start LED. An LED is lit while its
        // offset from the start stays below the scaled quotient.
        offset      = asc_reg ? (span_reg - cnt_reg) : cnt_reg;
        lit         = (dvd_reg[PROD_W-1:LED_W] != '0) || (dvd_reg[LED_W-1:0] > offset);
        final_range = ({1'b0, range_reg} + 2'd1) >= num_ranges;
    end

    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        range_next = range_reg;
        asc_next   = asc_reg;
        span_next  = span_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && num_ranges != 2'd0)
                begin
                    level_next = level;
                    range_next = 1'b0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                asc_next   = setup_asc;
                span_next  = setup_span;
                idx_next   = setup_asc ? cl_start : cl_end;
                dvd_next   = product[PROD_W-1:0];
                rem_next   = '0;
                cnt_next   = DIV_STEPS;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? rem_diff[LEVEL_W-1:0] : rem_shift[LEVEL_W-1:0];
                dvd_next = {dvd_reg[PROD_W-2:0], rem_ge};
                if (cnt_reg == '0)
                begin
                    cnt_next   = span_reg;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                idx_next = idx_reg + LED_W'(1);
                if (cnt_reg == '0)
                begin
                    if (final_range)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        range_next = 1'b1;
                        state_next = ST_SETUP;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            range_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            range_reg <= range_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        asc_reg   <= asc_next;
        span_reg  <= span_next;
        idx_reg   <= idx_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = (state_reg == ST_EMIT);
    assign led_index = idx_reg;
    assign color     = lit ? fg_color_reg : bg_color_reg;
    assign last      = strobe && (cnt_reg == '0) && final_range;

`ifndef SYNTHESIS
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("word strobed while block idle");

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last flag without a word");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !busy)
        else $error("block still busy after last word");

    a_no_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && num_ranges == 2'd0) |=> !busy)
        else $error("level with no ranges started work");

    a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |=> strobe)
        else $error("divider finished without emitting a word");
`endif

endmodule

`default_nettype wire
